>>> rtl/core/tmp_pkg.sv
// Package for the trapezoidal move profiler.
// Holds shared widths, codes, reset values and the configuration struct.
// No dependencies.
package tmp_pkg;

  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned SPEED_W = 15;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned ENC_W   = 32;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned FRAC_W  = 16;
  // headroom above the count width for 3p, 2s and the product feeding the divide
  localparam int unsigned GUARD_W = 18;
  // ramp gain 3*(cruise-min) and the quotient both fit in this many bits
  localparam int unsigned QUO_W   = 17;

  typedef enum logic [1:0] {
    OP_SAMPLE     = 2'd0,
    OP_START_TURN = 2'd1,
    OP_START_MOVE = 2'd2,
    OP_UNUSED     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    REG_MIN_SPEED  = 2'd0,
    REG_MAX_SPEED  = 2'd1,
    REG_TURN_GAIN  = 2'd2,
    REG_DIST_GAIN  = 2'd3
  } reg_idx_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  localparam logic [SPEED_W-1:0]       MIN_SPEED_RST = 15'd3277;
  localparam logic [SPEED_W-1:0]       MAX_SPEED_RST = 15'd16384;
  localparam logic signed [GAIN_W-1:0] TURN_GAIN_RST = -24'sd1970504;
  localparam logic signed [GAIN_W-1:0] DIST_GAIN_RST = 24'sd4551475;

  typedef struct packed {
    logic [SPEED_W-1:0]       min_speed;
    logic [SPEED_W-1:0]       max_speed;
    logic signed [GAIN_W-1:0] turn_counts_gain;
    logic signed [GAIN_W-1:0] distance_counts_gain;
  } cfg_t;

endpackage

>>> rtl/core/tmp_in_if.sv
// Input channel of the move profiler: valid/ready with the command payload.
// Depends on tmp_pkg for field widths.
interface tmp_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          opcode;
  logic signed [tmp_pkg::AMT_W-1:0]    move_amount;
  logic signed [tmp_pkg::ENC_W-1:0]    encoder_count;

  modport source (output valid, opcode, move_amount, encoder_count, input ready);
  modport sink   (input valid, opcode, move_amount, encoder_count, output ready);
endinterface

>>> rtl/core/tmp_out_if.sv
// Output channel of the move profiler: valid/ready with the wheel speed payload.
// Depends on tmp_pkg for field widths.
interface tmp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tmp_pkg::OUT_W-1:0]    left_speed;
  logic signed [tmp_pkg::OUT_W-1:0]    right_speed;
  logic                                move_done;

  modport source (output valid, left_speed, right_speed, move_done, input ready);
  modport sink   (input valid, left_speed, right_speed, move_done, output ready);
endinterface

>>> rtl/core/tmp_alu.sv
// Shared adder/subtractor of the move profiler datapath.
// Depends on tmp_pkg for the operation code.
module tmp_alu #(
  parameter int unsigned WIDTH = 50
) (
  input  tmp_pkg::alu_op_e    op_i,
  input  logic [WIDTH-1:0]    a_i,
  input  logic [WIDTH-1:0]    b_i,
  output logic [WIDTH-1:0]    res_o
);

  logic [WIDTH-1:0] b_eff;

  always_comb begin
    unique case (op_i)
      tmp_pkg::ALU_ADD: b_eff = b_i;
      tmp_pkg::ALU_SUB: b_eff = ~b_i;
      default:          b_eff = b_i;
    endcase
  end

  // carry-in of one completes the two's complement for subtract
  assign res_o = a_i + b_eff + WIDTH'(op_i == tmp_pkg::ALU_SUB);

endmodule

>>> rtl/core/tmp_regs.sv
// APB configuration registers of the move profiler.
// Depends on tmp_pkg for the register map, reset values and cfg_t.
module tmp_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmp_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmp_pkg::DATA_W-1:0]   pwdata,
  output logic [tmp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output tmp_pkg::cfg_t                cfg_o
);

  tmp_pkg::cfg_t     cfg_q;
  tmp_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = tmp_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed            <= tmp_pkg::MIN_SPEED_RST;
      cfg_q.max_speed            <= tmp_pkg::MAX_SPEED_RST;
      cfg_q.turn_counts_gain     <= tmp_pkg::TURN_GAIN_RST;
      cfg_q.distance_counts_gain <= tmp_pkg::DIST_GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        tmp_pkg::REG_MIN_SPEED: cfg_q.min_speed <= pwdata[tmp_pkg::SPEED_W-1:0];
        tmp_pkg::REG_MAX_SPEED: cfg_q.max_speed <= pwdata[tmp_pkg::SPEED_W-1:0];
        tmp_pkg::REG_TURN_GAIN: cfg_q.turn_counts_gain <= pwdata[tmp_pkg::GAIN_W-1:0];
        tmp_pkg::REG_DIST_GAIN: cfg_q.distance_counts_gain <= pwdata[tmp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tmp_pkg::REG_MIN_SPEED: prdata = tmp_pkg::DATA_W'(cfg_q.min_speed);
      tmp_pkg::REG_MAX_SPEED: prdata = tmp_pkg::DATA_W'(cfg_q.max_speed);
      tmp_pkg::REG_TURN_GAIN:
        prdata = tmp_pkg::DATA_W'(unsigned'(cfg_q.turn_counts_gain));
      tmp_pkg::REG_DIST_GAIN:
        prdata = tmp_pkg::DATA_W'(unsigned'(cfg_q.distance_counts_gain));
      default: prdata = '0;
    endcase
  end

endmodule

>>> rtl/core/tmp_core.sv
// Sequencer and datapath of the move profiler: phase tracking, ramp
// multiply and divide, all on one shared adder (tmp_alu).
// Depends on tmp_pkg, tmp_alu, tmp_in_if and tmp_out_if.
module tmp_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmp_pkg::cfg_t  cfg_i,
  tmp_in_if.sink         in_i,
  tmp_out_if.source      out_o
);

  localparam int unsigned CW  = COUNT_WIDTH;
  localparam int unsigned AW  = CW + tmp_pkg::GUARD_W;
  localparam int unsigned CNT_W = $clog2(tmp_pkg::QUO_W);

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_UP, PH_CRUISE, PH_DOWN
  } phase_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ABS, ST_DIFF, ST_NEG, ST_TRIPLE, ST_TEST1, ST_TEST2,
    ST_TEST3, ST_XPREP, ST_MUL, ST_DIV, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OM_DONE, OM_CRUISE, OM_RAMP
  } out_mode_e;

  state_e    state_q;
  phase_e    phase_q;
  out_mode_e mode_q;

  logic                      turn_q;
  logic [CW-1:0]             span_q;
  logic [CW-1:0]             s_q;
  logic [tmp_pkg::ENC_W-1:0] start_q;
  logic [tmp_pkg::ENC_W-1:0] enc_q;
  logic [AW-1:0]             p_q;
  logic [AW-1:0]             t_q;
  logic [AW-1:0]             x_q;
  logic [AW-1:0]             acc_q;
  logic [AW-1:0]             rem_q;
  logic [tmp_pkg::QUO_W-1:0] quo_q;
  logic [tmp_pkg::QUO_W-1:0] kval_q;
  logic [CNT_W-1:0]          cnt_q;

  logic                      out_valid_q;
  logic signed [tmp_pkg::OUT_W-1:0] left_q;
  logic signed [tmp_pkg::OUT_W-1:0] right_q;
  logic                      done_q;

  tmp_pkg::alu_op_e alu_op;
  logic [AW-1:0]    alu_a;
  logic [AW-1:0]    alu_b;
  logic [AW-1:0]    alu_res;

  logic                              rev;
  logic                              in_xfer;
  tmp_pkg::opcode_e                  op;
  logic signed [tmp_pkg::GAIN_W-1:0] gain_sel;
  logic signed [tmp_pkg::AMT_W+tmp_pkg::GAIN_W-1:0] prod;
  logic [63:0]                       span64;
  logic [63:0]                       enc64;
  logic [63:0]                       start64;
  logic [AW-1:0]                     span_ext;
  logic [AW-1:0]                     enc_ext;
  logic [AW-1:0]                     start_ext;
  logic [AW-1:0]                     s_ext;
  logic [AW-1:0]                     s2_ext;
  logic                              p_pos;
  logic                              div_ge;

  logic [tmp_pkg::SPEED_W-1:0]       cr;
  logic [tmp_pkg::SPEED_W-1:0]       cr_minus_mn;
  logic [tmp_pkg::QUO_W-1:0]         kval;
  logic [tmp_pkg::QUO_W:0]           ramp_sum;
  logic [tmp_pkg::SPEED_W-1:0]       v_mag;
  logic signed [tmp_pkg::OUT_W-1:0]  v_pos;
  logic signed [tmp_pkg::OUT_W-1:0]  v_left;
  logic signed [tmp_pkg::OUT_W-1:0]  v_right;
  logic                              out_free;

  tmp_alu #(.WIDTH(AW)) u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign op       = tmp_pkg::opcode_e'(in_i.opcode);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer  = in_i.valid && in_i.ready;

  // span = floor(amount * gain / 2^16), wrapped to the count width
  assign gain_sel = (op == tmp_pkg::OP_START_TURN) ? cfg_i.turn_counts_gain
                                                   : cfg_i.distance_counts_gain;
  assign prod     = in_i.move_amount * gain_sel;
  assign span64   = 64'(signed'(prod[tmp_pkg::AMT_W+tmp_pkg::GAIN_W-1:tmp_pkg::FRAC_W]));

  assign enc64    = 64'(signed'(enc_q));
  assign start64  = 64'(signed'(start_q));
  assign rev      = span_q[CW-1];
  assign span_ext = {{tmp_pkg::GUARD_W{span_q[CW-1]}}, span_q};
  assign enc_ext  = {{tmp_pkg::GUARD_W{enc64[CW-1]}}, enc64[CW-1:0]};
  assign start_ext = {{tmp_pkg::GUARD_W{start64[CW-1]}}, start64[CW-1:0]};
  assign s_ext    = {{tmp_pkg::GUARD_W{1'b0}}, s_q};
  assign s2_ext   = {{(tmp_pkg::GUARD_W-1){1'b0}}, s_q, 1'b0};
  assign p_pos    = !p_q[AW-1] && (p_q != '0);
  assign div_ge   = !alu_res[AW-1];

  // shared adder operand select
  always_comb begin
    alu_op = tmp_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      ST_ABS: begin
        alu_op = rev ? tmp_pkg::ALU_SUB : tmp_pkg::ALU_ADD;
        alu_a  = rev ? '0 : span_ext;
        alu_b  = rev ? span_ext : '0;
      end
      ST_DIFF: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = enc_ext;
        alu_b  = start_ext;
      end
      ST_NEG: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = rev ? '0 : p_q;
        alu_b  = rev ? p_q : '0;
      end
      ST_TRIPLE: begin
        alu_a  = {p_q[AW-2:0], 1'b0};
        alu_b  = p_q;
      end
      ST_TEST1: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = t_q;
        alu_b  = s_ext;
      end
      ST_TEST2: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = t_q;
        alu_b  = s2_ext;
      end
      ST_TEST3: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = p_q;
        alu_b  = s_ext;
      end
      ST_XPREP: begin
        if (phase_q == PH_UP) begin
          alu_a = p_pos ? p_q : '0;
        end else begin
          alu_op = tmp_pkg::ALU_SUB;
          alu_a  = s_ext;
          alu_b  = p_q;
        end
      end
      ST_MUL: begin
        alu_a  = {acc_q[AW-2:0], 1'b0};
        alu_b  = kval_q[cnt_q] ? x_q : '0;
      end
      ST_DIV: begin
        alu_op = tmp_pkg::ALU_SUB;
        alu_a  = {rem_q[AW-2:0], quo_q[tmp_pkg::QUO_W-1]};
        alu_b  = s_ext;
      end
      ST_IDLE, ST_OUT: ;
      default: ;
    endcase
  end

  // speed shaping
  assign cr          = (cfg_i.max_speed > cfg_i.min_speed) ? cfg_i.max_speed
                                                           : cfg_i.min_speed;
  assign cr_minus_mn = cr - cfg_i.min_speed;
  assign kval        = {1'b0, cr_minus_mn, 1'b0} + {2'b0, cr_minus_mn};
  assign ramp_sum    = {3'b0, cfg_i.min_speed} + {1'b0, quo_q};
  always_comb begin
    unique case (mode_q)
      OM_RAMP:  v_mag = (ramp_sum > {3'b0, cr}) ? cr : ramp_sum[tmp_pkg::SPEED_W-1:0];
      OM_CRUISE: v_mag = cr;
      OM_DONE:  v_mag = '0;
      default:  v_mag = '0;
    endcase
  end
  assign v_pos    = {1'b0, v_mag};
  assign v_left   = rev ? -v_pos : v_pos;
  assign v_right  = turn_q ? -v_left : v_left;
  assign out_free = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.left_speed  = left_q;
  assign out_o.right_speed = right_q;
  assign out_o.move_done   = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      mode_q      <= OM_DONE;
      turn_q      <= 1'b0;
      span_q      <= '0;
      s_q         <= '0;
      start_q     <= '0;
      enc_q       <= '0;
      p_q         <= '0;
      t_q         <= '0;
      x_q         <= '0;
      acc_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      kval_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      right_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      // drop the taken result unless ST_OUT reloads the register this cycle
      if (out_valid_q && out_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (op == tmp_pkg::OP_START_TURN || op == tmp_pkg::OP_START_MOVE) begin
              span_q  <= span64[CW-1:0];
              turn_q  <= (op == tmp_pkg::OP_START_TURN);
              phase_q <= PH_WAIT;
              state_q <= ST_ABS;
            end else if (op == tmp_pkg::OP_SAMPLE && phase_q != PH_IDLE) begin
              enc_q <= in_i.encoder_count;
              if (phase_q == PH_WAIT) begin
                start_q <= in_i.encoder_count;
                phase_q <= PH_UP;
              end
              if (span_q == '0) begin
                phase_q <= PH_IDLE;
                mode_q  <= OM_DONE;
                state_q <= ST_OUT;
              end else begin
                state_q <= ST_DIFF;
              end
            end
          end
        end
        ST_ABS: begin
          s_q     <= alu_res[CW-1:0];
          state_q <= ST_IDLE;
        end
        ST_DIFF: begin
          // wrap the difference to the count width, then widen
          p_q     <= {{tmp_pkg::GUARD_W{alu_res[CW-1]}}, alu_res[CW-1:0]};
          state_q <= ST_NEG;
        end
        ST_NEG: begin
          p_q     <= alu_res;
          state_q <= ST_TRIPLE;
        end
        ST_TRIPLE: begin
          t_q     <= alu_res;
          state_q <= ST_TEST1;
        end
        ST_TEST1: begin
          if (phase_q == PH_UP && alu_res[AW-1]) begin
            state_q <= ST_XPREP;
          end else begin
            if (phase_q == PH_UP) begin
              phase_q <= PH_CRUISE;
            end
            state_q <= ST_TEST2;
          end
        end
        ST_TEST2: begin
          if (phase_q == PH_CRUISE && alu_res[AW-1]) begin
            mode_q  <= OM_CRUISE;
            state_q <= ST_OUT;
          end else begin
            phase_q <= PH_DOWN;
            state_q <= ST_TEST3;
          end
        end
        ST_TEST3: begin
          if (!alu_res[AW-1]) begin
            phase_q <= PH_IDLE;
            mode_q  <= OM_DONE;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_XPREP;
          end
        end
        ST_XPREP: begin
          x_q    <= alu_res;
          kval_q <= kval;
          acc_q  <= '0;
          cnt_q  <= CNT_W'(tmp_pkg::QUO_W - 1);
          // ramp down with no forward progress already meets the cruise cap
          if (phase_q == PH_DOWN && !p_pos) begin
            mode_q  <= OM_CRUISE;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q <= alu_res;
          if (cnt_q == '0) begin
            rem_q   <= AW'(alu_res[AW-1:tmp_pkg::QUO_W]);
            quo_q   <= alu_res[tmp_pkg::QUO_W-1:0];
            cnt_q   <= CNT_W'(tmp_pkg::QUO_W - 1);
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_DIV: begin
          rem_q <= div_ge ? alu_res : alu_a;
          quo_q <= {quo_q[tmp_pkg::QUO_W-2:0], div_ge};
          if (cnt_q == '0) begin
            mode_q  <= OM_RAMP;
            state_q <= ST_OUT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_OUT: begin
          // hold here while an earlier result still waits
          if (out_free) begin
            out_valid_q <= 1'b1;
            left_q      <= v_left;
            right_q     <= v_right;
            done_q      <= (mode_q == OM_DONE);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/trapezoidal_move_profiler.sv
// Trapezoidal move profiler. A start command (opcode 1 turn, 2 straight) is
// taken in ST_IDLE and passes ST_ABS, which stores the span magnitude, before
// the next item is accepted. An encoder sample (opcode 0) in ramp up or ramp
// down runs adder steps for the phase tests, then 17 shift-add multiply
// steps and 17 restoring divide steps, all on one shared adder/subtractor
// of COUNT_WIDTH+18 bits. Cruise samples, the final sample of a move (also
// when the span is zero) and a ramp-down sample with no forward progress
// skip the multiply and divide. Samples while idle and opcode 3 are dropped.
// Results sit in an output register, so a new item can be taken while one
// waits; a further result holds the sequencer until it is free.
// Depends on tmp_pkg, tmp_in_if, tmp_out_if, tmp_regs and tmp_core.
module trapezoidal_move_profiler #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmp_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmp_pkg::DATA_W-1:0]   pwdata,
  output logic [tmp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  tmp_in_if.sink                       in_i,
  tmp_out_if.source                    out_o
);

  tmp_pkg::cfg_t cfg;

  tmp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmp_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule

>>> tb/sv/move_speed_check.sv
// Speed command checker for the trapezoidal move profiler testbench.
// Watches the command, speed and APB channels, predicts each wheel speed result and compares.
// Depends on tmp_pkg, tmp_in_if and tmp_out_if.
module move_speed_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tmp_pkg::ADDR_W-1:0] paddr,
  input  logic [tmp_pkg::DATA_W-1:0] pwdata,
  input  logic                       pready,
  tmp_in_if                          cmd_i,
  tmp_out_if                         speed_i,
  output int                         mismatches_o,
  output int                         outstanding_o
);
  import tmp_pkg::*;

  typedef enum logic [2:0] {
    MV_IDLE      = 3'd0,
    MV_WAIT      = 3'd1,
    MV_RAMP_UP   = 3'd2,
    MV_CRUISE    = 3'd3,
    MV_RAMP_DOWN = 3'd4
  } move_phase_e;

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    done;
  } wheel_cmd_t;

  logic [SPEED_W-1:0]       min_q;
  logic [SPEED_W-1:0]       max_q;
  logic signed [GAIN_W-1:0] turn_gain_q;
  logic signed [GAIN_W-1:0] dist_gain_q;

  move_phase_e              phase_q;
  logic                     turn_q;
  logic signed [ENC_W-1:0]  origin_q;
  logic signed [31:0]       span_q;

  wheel_cmd_t               wheel_cmds_q[$];
  wheel_cmd_t               want;
  int                       errors;

  // Update the profile state for one accepted command and queue any wheel command it causes.
  task automatic advance_profile(input logic [1:0] op, input logic signed [AMT_W-1:0] amt,
                                 input logic signed [ENC_W-1:0] enc);
    longint                   prod;
    longint                   s;
    longint                   p;
    longint                   mn;
    longint                   cr;
    longint                   v;
    longint                   nv;
    longint                   pc;
    logic signed [31:0]       diff;
    logic signed [GAIN_W-1:0] gain;
    logic                     rev;
    logic                     finished;
    wheel_cmd_t               res;
    if (op == OP_START_TURN || op == OP_START_MOVE) begin
      gain    = (op == OP_START_TURN) ? turn_gain_q : dist_gain_q;
      prod    = longint'(amt) * longint'(gain);
      // arithmetic shift floors; the slice wraps to the count width
      span_q  = prod[47:16];
      turn_q  = (op == OP_START_TURN);
      phase_q = MV_WAIT;
    end else if (op == OP_SAMPLE && phase_q != MV_IDLE) begin
      if (phase_q == MV_WAIT) begin
        origin_q = enc;
        phase_q  = MV_RAMP_UP;
      end
      rev      = span_q[31];
      s        = rev ? -longint'(span_q) : longint'(span_q);
      diff     = enc - origin_q;
      p        = rev ? -longint'(diff) : longint'(diff);
      mn       = longint'(min_q);
      cr       = (max_q > min_q) ? longint'(max_q) : longint'(min_q);
      finished = 1'b0;
      v        = 0;
      if (s == 0) begin
        finished = 1'b1;
      end else begin
        if (phase_q == MV_RAMP_UP && !(3 * p < s)) phase_q = MV_CRUISE;
        if (phase_q == MV_CRUISE && !(3 * p < 2 * s)) phase_q = MV_RAMP_DOWN;
        if (phase_q == MV_RAMP_DOWN && !(p < s)) begin
          finished = 1'b1;
        end else if (phase_q == MV_RAMP_UP) begin
          pc = (p > 0) ? p : 0;
          v  = mn + (3 * (cr - mn) * pc) / s;
        end else if (phase_q == MV_CRUISE) begin
          v = cr;
        end else begin
          v = mn + (3 * (cr - mn) * (s - p)) / s;
          if (v > cr) v = cr;
        end
      end
      if (finished) begin
        phase_q   = MV_IDLE;
        res.left  = '0;
        res.right = '0;
        res.done  = 1'b1;
      end else begin
        if (rev) v = -v;
        nv        = -v;
        res.left  = v[OUT_W-1:0];
        res.right = turn_q ? nv[OUT_W-1:0] : v[OUT_W-1:0];
        res.done  = 1'b0;
      end
      wheel_cmds_q = {wheel_cmds_q, res};
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       = MIN_SPEED_RST;
      max_q       = MAX_SPEED_RST;
      turn_gain_q = TURN_GAIN_RST;
      dist_gain_q = DIST_GAIN_RST;
      phase_q     = MV_IDLE;
      turn_q      = 1'b0;
      origin_q    = '0;
      span_q      = '0;
      wheel_cmds_q.delete();
      errors      = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      // retire the output side first: a result can never come from this edge's command
      if (speed_i.valid && speed_i.ready) begin
        if (wheel_cmds_q.size() == 0) begin
          if (errors < 10) begin
            $display("unexpected speed result: L=%0d R=%0d done=%0b",
                     speed_i.left_speed, speed_i.right_speed, speed_i.move_done);
          end
          errors++;
        end else begin
          want = wheel_cmds_q.pop_front();
          if (speed_i.left_speed !== want.left || speed_i.right_speed !== want.right ||
              speed_i.move_done !== want.done) begin
            if (errors < 10) begin
              $display("speed mismatch: exp L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                       want.left, want.right, want.done,
                       speed_i.left_speed, speed_i.right_speed, speed_i.move_done);
            end
            errors++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[ADDR_W-1:2]))
          REG_MIN_SPEED: min_q       = pwdata[SPEED_W-1:0];
          REG_MAX_SPEED: max_q       = pwdata[SPEED_W-1:0];
          REG_TURN_GAIN: turn_gain_q = pwdata[GAIN_W-1:0];
          REG_DIST_GAIN: dist_gain_q = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.valid && cmd_i.ready) begin
        advance_profile(cmd_i.opcode, cmd_i.move_amount, cmd_i.encoder_count);
      end
      mismatches_o  <= errors;
      outstanding_o <= wheel_cmds_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the trapezoidal move profiler testbench: clock, reset, APB writes,
// command stimulus, output pacing, watchdog and verdict.
// Depends on tmp_pkg, tmp_in_if, tmp_out_if, move_speed_check and the profiler RTL.
module testbench;
  import tmp_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned LONG_HOLD     = 400;

  typedef enum int {
    RX_OPEN,
    RX_CHOPPY,
    RX_STALL
  } rx_mode_e;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int                mismatches;
  int                outstanding;
  bit                hold_off_req;
  int                burst_left;
  int                items_sent;

  logic signed [GAIN_W-1:0] turn_gain_cfg;
  logic signed [GAIN_W-1:0] dist_gain_cfg;

  tmp_in_if  cmd_if ();
  tmp_out_if speed_if ();

  trapezoidal_move_profiler u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (cmd_if),
    .out_o   (speed_if)
  );

  move_speed_check u_speed_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .cmd_i         (cmd_if),
    .speed_i       (speed_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offer one command in bursts with random gaps, hold it until the transfer.
  task automatic send(input opcode_e op, input logic [AMT_W-1:0] amt,
                      input logic [ENC_W-1:0] enc);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 30);
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_if.valid         <= 1'b1;
    cmd_if.opcode        <= op;
    cmd_if.move_amount   <= amt;
    cmd_if.encoder_count <= enc;
    do @(posedge clk); while (!cmd_if.ready);
    items_sent++;
  endtask

  // Stop offering and wait for every predicted result.
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apply_config(input logic [SPEED_W-1:0] mn, input logic [SPEED_W-1:0] mx,
                              input logic [GAIN_W-1:0] tg, input logic [GAIN_W-1:0] dg);
    drain_results();
    // a start or a dropped sample may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_MIN_SPEED, {17'd0, mn});
    reg_write(REG_MAX_SPEED, {17'd0, mx});
    reg_write(REG_TURN_GAIN, {8'd0, tg});
    reg_write(REG_DIST_GAIN, {8'd0, dg});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    turn_gain_cfg = tg;
    dist_gain_cfg = dg;
  endtask

  // One move: start, first sample, then samples stepping through the span.
  // A broken move stops after a few samples and is cut off by the next start.
  task automatic run_move(input bit broken);
    opcode_e                  op;
    logic signed [AMT_W-1:0]  amt;
    logic signed [GAIN_W-1:0] gain;
    logic signed [31:0]       span;
    logic signed [ENC_W-1:0]  origin;
    longint                   prod;
    longint                   s;
    longint                   off;
    longint                   step;
    longint                   delta;
    longint                   dirn;
    int                       n;
    int                       n_max;
    op   = $urandom_range(0, 1) ? OP_START_TURN : OP_START_MOVE;
    amt  = AMT_W'(($urandom_range(0, 3) == 0) ? ($urandom_range(0, 8) - 4) : $urandom);
    gain = (op == OP_START_TURN) ? turn_gain_cfg : dist_gain_cfg;
    prod = longint'(amt) * longint'(gain);
    span = prod[47:16];
    s    = span[31] ? -longint'(span) : longint'(span);
    dirn = span[31] ? -1 : 1;
    send(op, amt, $urandom);
    origin = $urandom;
    send(OP_SAMPLE, AMT_W'($urandom), origin);
    step = s / $urandom_range(2, 12);
    if (step == 0) step = 1;
    off   = 0;
    n     = 0;
    n_max = broken ? $urandom_range(0, 3) : 30;
    while (off * dirn < s && n < n_max) begin
      if ($urandom_range(0, 9) == 0) delta = -(step / 2);
      else delta = step + ($urandom % (step / 4 + 1));
      off = off + dirn * delta;
      if (!broken && n == n_max - 1) off = dirn * s;
      send(OP_SAMPLE, AMT_W'($urandom), origin + off[31:0]);
      n++;
    end
  endtask

  task automatic run_random(input int n_items);
    int target;
    int r;
    target = items_sent + n_items;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 78) run_move(1'b0);
      else if (r < 88) run_move(1'b1);
      else if (r < 96) send(opcode_e'($urandom_range(0, 3)), AMT_W'($urandom), $urandom);
      else drain_results();
    end
  endtask

  // Output pacing: open, choppy and stalled stretches, plus a long hold on request.
  initial begin : sink_pacing
    rx_mode_e mode;
    int       len;
    int       r;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        mode = RX_STALL;
        len  = LONG_HOLD;
      end else begin
        r = $urandom_range(0, 9);
        if (r < 4) begin
          mode = RX_OPEN;
          len  = $urandom_range(1, 60);
        end else if (r < 8) begin
          mode = RX_CHOPPY;
          len  = $urandom_range(1, 40);
        end else begin
          mode = RX_STALL;
          len  = $urandom_range(1, 12);
        end
      end
      repeat (len) begin
        case (mode)
          RX_OPEN:   speed_if.ready <= 1'b1;
          RX_CHOPPY: speed_if.ready <= 1'($urandom_range(0, 1));
          default:   speed_if.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (speed_if.valid && speed_if.ready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int ramp_offs[7];
    ramp_offs = '{0, 10, 23, 46, 5, 68, 69};
    hold_off_req  = 1'b0;
    burst_left    = 0;
    items_sent    = 0;
    turn_gain_cfg = TURN_GAIN_RST;
    dist_gain_cfg = DIST_GAIN_RST;
    rst_n                <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    cmd_if.valid         <= 1'b0;
    cmd_if.opcode        <= OP_SAMPLE;
    cmd_if.move_amount   <= '0;
    cmd_if.encoder_count <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset configuration
    send(OP_SAMPLE, 16'h7fff, 32'd0);
    send(OP_UNUSED, 16'hffff, 32'hffffffff);
    send(OP_START_TURN, 16'h0000, 32'h7fffffff);
    send(OP_SAMPLE, 16'h0000, 32'h7fffffff);
    // short move: exact phase boundaries, a backward sample in ramp down, then the target
    send(OP_START_MOVE, 16'h0001, 32'h0000_0000);
    foreach (ramp_offs[i]) send(OP_SAMPLE, AMT_W'($urandom), 32'h8000_0000 + ramp_offs[i]);
    // restart while waiting, reverse turn, backward sample across the wrap in cruise
    send(OP_START_TURN, 16'h8000, 32'd0);
    send(OP_START_TURN, 16'h7fff, 32'd0);
    send(OP_SAMPLE, 16'h0000, 32'h7fffffff);
    send(OP_SAMPLE, 16'h0000, 32'h7fffffff - 32'd400000);
    send(OP_SAMPLE, 16'h0000, 32'h80000000);
    // drop the running move for a reverse straight one and overshoot it
    send(OP_START_MOVE, 16'h8000, 32'd0);
    send(OP_SAMPLE, 16'h0000, 32'd5);
    send(OP_SAMPLE, 16'h0000, -32'sd3000000);
    drain_results();

    run_random(250);

    apply_config(15'd0, 15'h7fff, 24'h7fffff, 24'h800000);
    hold_off_req = 1'b1;
    run_random(270);

    // cruise below min: min takes over
    apply_config(15'h7fff, 15'd0, 24'h800000, 24'h7fffff);
    run_random(250);

    begin : flat_small_gains
      logic [SPEED_W-1:0] spd;
      logic [GAIN_W-1:0]  tg;
      spd = SPEED_W'($urandom);
      tg  = GAIN_W'($urandom_range(1, 70000));
      if ($urandom_range(0, 1)) tg = -tg;
      apply_config(spd, spd, tg, GAIN_W'($urandom));
    end
    run_random(250);

    apply_config(SPEED_W'($urandom), SPEED_W'($urandom), GAIN_W'($urandom),
                 GAIN_W'($urandom));
    hold_off_req = 1'b1;
    run_random(300);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tmp_pkg.sv
rtl/core/tmp_in_if.sv
rtl/core/tmp_out_if.sv
rtl/core/tmp_alu.sv
rtl/core/tmp_regs.sv
rtl/core/tmp_core.sv
rtl/core/trapezoidal_move_profiler.sv
tb/sv/move_speed_check.sv
tb/sv/testbench.sv
